### src/deadline_timer_bank_assert.svh
// assertion macros for the deadline timer bank checker
// no dependencies; taken in by the checker file
`ifndef DEADLINE_TIMER_BANK_ASSERT_SVH
`define DEADLINE_TIMER_BANK_ASSERT_SVH

// same-cycle implication, reset disables
`define DTB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deadline timer bank check failed");

// next-cycle implication, reset disables
`define DTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deadline timer bank check failed");

`endif

### src/dtb_pkg.sv
// shared types, codes and sizes for the deadline timer bank
// no dependencies
`default_nettype none

package dtb_pkg;

	// bank size; timer 0 is never used
	localparam int TIMERS  = 8;
	localparam int TIMER_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	// cycles from accepted beat to result strobe
	localparam int LATENCY = TIMERS + 1;

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	// item modes
	localparam logic [1:0] MODE_QUERY = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_SET   = 2'd2;
	localparam logic [1:0] MODE_STOP  = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  timer_index;
		logic [15:0] offset;
	} item_t;

	typedef struct packed {
		logic [7:0]         due_mask;
		logic               selected_running;
		logic               selected_due;
		logic signed [31:0] selected_left;
		logic signed [31:0] next_due_in;
		logic               none_running;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_SCAN,
		ST_REPORT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic               load;
		logic               apply;
		logic               scan;
		logic [TIMER_W-1:0] scan_idx;
	} cmd_t;

endpackage

`default_nettype wire

### src/dtb_ctrl.sv
// controller for the deadline timer bank: sequences load, apply, scan, report
// depends on dtb_pkg
`default_nettype none

module dtb_ctrl import dtb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	output cmd_t      cmd
);

	state_t             state_q, state_d;
	logic [TIMER_W-1:0] scan_idx_q, scan_idx_d;

	// state and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= TIMER_W'(1);
		end else begin
			state_q    <= state_d;
			scan_idx_q <= scan_idx_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		scan_idx_d   = scan_idx_q;
		cmd.load     = 1'b0;
		cmd.apply    = 1'b0;
		cmd.scan     = 1'b0;
		cmd.scan_idx = scan_idx_q;
		busy         = 1'b1;
		done         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply  = 1'b1;
				scan_idx_d = TIMER_W'(1);
				state_d    = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (scan_idx_q == TIMER_W'(TIMERS - 1)) begin
					state_d = ST_REPORT;
				end else begin
					scan_idx_d = scan_idx_q + TIMER_W'(1);
				end
			end
			ST_REPORT: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

### src/dtb_datapath.sv
// datapath for the deadline timer bank: counter, deadline store, scan accumulators
// depends on dtb_pkg
`default_nettype none

module dtb_datapath import dtb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cmd_t  cmd,
	input  wire item_t item,
	output result_t    result
);

	item_t              item_q;
	logic [31:0]        now_q;
	logic [31:0]        deadline_q [TIMERS];

	logic [7:0]         due_q;
	logic               any_q;
	logic signed [31:0] best_q;
	logic               sel_run_q;
	logic               sel_due_q;
	logic signed [31:0] sel_left_q;

	logic               idx_ok;
	logic [TIMER_W-1:0] wr_idx;
	logic [32:0]        sum;
	logic [31:0]        set_val;
	logic [31:0]        rd;
	logic signed [32:0] diff;
	logic signed [31:0] left;
	logic               is_due;
	logic               sel_hit;

	// item register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	// set deadline, saturating at the counter limit
	assign idx_ok  = (item_q.timer_index != 3'd0) && (32'(item_q.timer_index) < TIMERS);
	assign wr_idx  = TIMER_W'(item_q.timer_index);
	assign sum     = {1'b0, now_q} + {17'd0, item_q.offset};
	assign set_val = sum[32] ? COUNT_MAX : sum[31:0];

	// remaining time of the scanned timer, clamped to signed 32 bits
	assign rd     = deadline_q[cmd.scan_idx];
	assign diff   = $signed({1'b0, rd}) - $signed({1'b0, now_q});
	assign left   = (diff > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
	                (diff < -33'sh0_8000_0000) ? 32'sh8000_0000 : diff[31:0];
	assign is_due = (rd <= now_q);
	assign sel_hit = (32'(cmd.scan_idx) == 32'(item_q.timer_index)) && (rd != 32'd0);

	// seconds counter and deadline store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= 32'd1;
			for (int i = 0; i < TIMERS; i++) begin
				deadline_q[i] <= 32'd0;
			end
		end else if (cmd.apply) begin
			case (item_q.mode)
				MODE_TICK: if (now_q != COUNT_MAX) now_q <= now_q + 32'd1;
				MODE_SET:  if (idx_ok) deadline_q[wr_idx] <= set_val;
				MODE_STOP: if (idx_ok) deadline_q[wr_idx] <= 32'd0;
				default: ;
			endcase
		end
	end

	// scan accumulators, cleared on apply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_q      <= 8'd0;
			any_q      <= 1'b0;
			best_q     <= '0;
			sel_run_q  <= 1'b0;
			sel_due_q  <= 1'b0;
			sel_left_q <= '0;
		end else if (cmd.apply) begin
			due_q      <= 8'd0;
			any_q      <= 1'b0;
			best_q     <= '0;
			sel_run_q  <= 1'b0;
			sel_due_q  <= 1'b0;
			sel_left_q <= '0;
		end else if (cmd.scan && (rd != 32'd0)) begin
			for (int b = 0; b < 8; b++) begin
				if ((32'(cmd.scan_idx) == b) && is_due) begin
					due_q[b] <= 1'b1;
				end
			end
			if (!any_q || (left < best_q)) begin
				best_q <= left;
			end
			any_q <= 1'b1;
			if (sel_hit) begin
				sel_run_q  <= 1'b1;
				sel_due_q  <= is_due;
				sel_left_q <= left;
			end
		end
	end

	// result beat from accumulators
	always_comb begin
		result.due_mask         = due_q;
		result.selected_running = sel_run_q;
		result.selected_due     = sel_due_q;
		result.selected_left    = sel_left_q;
		result.next_due_in      = any_q ? best_q : -32'sd1;
		result.none_running     = !any_q;
	end

endmodule

`default_nettype wire

### src/deadline_timer_bank.sv
// top level of the deadline timer bank: controller plus datapath
// depends on dtb_pkg, dtb_ctrl, dtb_datapath
//
//   channel   ports                 handshake
//   item      start, busy, item     beat taken when start and not busy
//   result    done, result          one-cycle strobe, no backpressure
//
// every item passes through one apply state, a scan of timers 1..TIMERS-1
// one at a time through the single deadline read port, and one report
// state. busy rises after acceptance and stays high through the result beat,
// so the next beat is taken only once the controller is back in idle.
// reset sets the counter to 1 and stops all timers; no clearing pass.
// results cannot be stalled; done pulses for exactly one cycle per item.
`default_nettype none

module deadline_timer_bank import dtb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire item_t item,
	output logic       busy,
	output logic       done,
	output result_t    result
);

	cmd_t cmd;

	// sequencer
	dtb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// timer state and scan
	dtb_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

endmodule

`default_nettype wire

### src/dtb_checker.sv
// port-level checks for the deadline timer bank, bound to the top level
// depends on dtb_pkg and deadline_timer_bank_assert.svh
`default_nettype none
`include "deadline_timer_bank_assert.svh"

module dtb_checker import dtb_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire logic    done,
	input wire result_t result
);

	logic empty_ok;
	logic stop_ok;

	// expected look of an empty bank and of a stopped selection
	assign empty_ok = (result.next_due_in == -32'sd1) && (result.due_mask == 8'd0) &&
	                  !result.selected_running;
	assign stop_ok  = !result.selected_due && (result.selected_left == 32'sd0);

	// accepted beat produces its result after a fixed latency
	`DTB_ASSERT_NOW(a_latency, clk, arst_n, start && !busy, ##LATENCY done)
	// one cycle strobe per item
	`DTB_ASSERT_NEXT(a_single, clk, arst_n, done, !done)
	// no result while idle
	`DTB_ASSERT_NOW(a_done_busy, clk, arst_n, done, busy)
	// empty bank reports minus one and nothing due
	`DTB_ASSERT_NOW(a_empty, clk, arst_n, done && result.none_running, empty_ok)
	// stopped selection shows no time left
	`DTB_ASSERT_NOW(a_sel_stop, clk, arst_n, done && !result.selected_running, stop_ok)

endmodule

bind deadline_timer_bank dtb_checker u_dtb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire
